// ----- rtl/core/prlec_pkg.sv -----
// ----------------------------------------------------------------------------
// prlec_pkg
// shared types, codes and constants of the priority rgb led effect controller
// ----------------------------------------------------------------------------
`default_nettype none

package prlec_pkg;

    localparam int NUM_LEVELS_DEF = 5;
    localparam int LEVEL_W        = 3;
    localparam int COLOUR_W       = 8;
    localparam int PERIOD_W       = 16;
    localparam int IN_DATA_W      = 48;
    localparam int OUT_DATA_W     = 32;
    localparam int PADDR_W        = 3;
    localparam int PDATA_W        = 32;
    localparam int DIV_STEPS      = 9;
    localparam int DIV_CNT_W      = 4;

    localparam logic [PADDR_W-1:0] ADDR_COMMON_ANODE = 3'd0;

    localparam logic [1:0] ACT_TICK    = 2'd0;
    localparam logic [1:0] ACT_SET     = 2'd1;
    localparam logic [1:0] ACT_RELEASE = 2'd2;
    localparam logic [1:0] ACT_ALL_OFF = 2'd3;

    localparam logic [1:0] EFF_OFF   = 2'd0;
    localparam logic [1:0] EFF_SOLID = 2'd1;
    localparam logic [1:0] EFF_BLINK = 2'd2;
    localparam logic [1:0] EFF_PULSE = 2'd3;

    typedef struct packed {
        logic [COLOUR_W-1:0] red;
        logic [COLOUR_W-1:0] green;
        logic [COLOUR_W-1:0] blue;
        logic [1:0]          effect;
        logic [PERIOD_W-1:0] period;
    } led_entry_t;

    typedef struct packed {
        logic load_in;
        logic exec_cmd;
        logic tick_direct;
        logic div_start;
        logic div_step;
        logic mul;
        logic scale;
        logic commit;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic is_tick;
        logic pulse;
        logic div_last;
        logic out_free;
    } dp_status_t;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_DECODE = 7'b0000010,
        ST_DIV    = 7'b0000100,
        ST_MUL    = 7'b0001000,
        ST_SCALE  = 7'b0010000,
        ST_COMMIT = 7'b0100000,
        ST_RESULT = 7'b1000000
    } ctrl_state_t;

endpackage

`default_nettype wire

// ----- rtl/core/prlec_ctrl.sv -----
// ----------------------------------------------------------------------------
// prlec_ctrl
// sequencer: accepts one item, steps the datapath through it, hands off result
// ----------------------------------------------------------------------------
`default_nettype none

module prlec_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire prlec_pkg::dp_status_t status,
    output prlec_pkg::dp_cmd_t        cmd
);
    import prlec_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (!status.is_tick)
                begin
                    cmd.exec_cmd = 1'b1;
                    state_next   = ST_RESULT;
                end
                else if (status.pulse)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
                else
                begin
                    cmd.tick_direct = 1'b1;
                    state_next      = ST_COMMIT;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/prlec_datapath.sv -----
// ----------------------------------------------------------------------------
// prlec_datapath
// request slots, active request, phase, serial brightness divider and scaling
// ----------------------------------------------------------------------------
`default_nettype none

module prlec_datapath #(
    parameter int NUM_LEVELS = prlec_pkg::NUM_LEVELS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire prlec_pkg::dp_cmd_t                cmd,
    output prlec_pkg::dp_status_t                  status,
    input  wire logic                              common_anode,
    input  wire logic [1:0]                        action,
    input  wire logic [prlec_pkg::LEVEL_W-1:0]     level,
    input  wire prlec_pkg::led_entry_t             req,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [prlec_pkg::OUT_DATA_W-1:0]       out_data
);
    import prlec_pkg::*;

    localparam int LVL_W = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
    localparam int HALF_W = PERIOD_W - 1;
    localparam int REM_W  = PERIOD_W + COLOUR_W;
    localparam int DIVR_W = HALF_W + COLOUR_W;
    localparam int COL_W  = 3 * COLOUR_W;
    localparam int PROD_W = 2 * COLOUR_W;

    led_entry_t                slot_entry_reg [NUM_LEVELS];
    logic [NUM_LEVELS-1:0]     slot_valid_reg;
    logic [NUM_LEVELS-1:0]     slot_valid_next;
    logic                      slot_we;

    logic [1:0]                in_action_reg;
    logic [LEVEL_W-1:0]        in_level_reg;
    led_entry_t                in_req_reg;

    led_entry_t                act_entry_reg, act_entry_next;
    logic [LEVEL_W-1:0]        act_prio_reg, act_prio_next;
    logic [PERIOD_W-1:0]       phase_reg, phase_next;
    logic [COL_W-1:0]          shown_reg, shown_next;
    logic                      changed_reg, changed_next;
    logic [COL_W-1:0]          col_reg, col_next;
    logic [REM_W-1:0]          rem_reg, rem_next;
    logic [DIVR_W-1:0]         divr_reg, divr_next;
    logic [DIV_STEPS-1:0]      quot_reg, quot_next;
    logic [DIV_CNT_W-1:0]      cnt_reg, cnt_next;
    logic [PROD_W-1:0]         prod_reg [3];
    logic [PROD_W-1:0]         prod_next [3];
    logic                      out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0]     out_data_reg, out_data_next;

    logic [HALF_W-1:0]         half;
    logic                      ph_lt_half;
    logic                      level_ok;
    logic [LVL_W-1:0]          level_idx;
    logic                      top_found;
    logic [LVL_W-1:0]          top_idx;
    logic [PERIOD_W-1:0]       bright_base;
    logic [PERIOD_W:0]         phase_inc;
    logic [COLOUR_W-1:0]       bright;
    logic [PROD_W-1:0]         scale_sum [3];
    logic [COL_W-1:0]          colour;

    assign half       = act_entry_reg.period[PERIOD_W-1:1];
    assign ph_lt_half = phase_reg < {1'b0, half};
    assign level_ok   = {1'b0, in_level_reg} < (LEVEL_W + 1)'(NUM_LEVELS);
    assign level_idx  = in_level_reg[LVL_W-1:0];
    assign colour     = {act_entry_reg.red, act_entry_reg.green, act_entry_reg.blue};
    assign bright     = quot_reg[DIV_STEPS-1] ? 8'hFF : quot_reg[COLOUR_W-1:0];
    assign phase_inc  = {1'b0, phase_reg} + 17'd1;
    assign bright_base = ph_lt_half ? phase_reg : (act_entry_reg.period - phase_reg);

    // divide by 255 of a product below 2^16
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            scale_sum[i] = prod_reg[i] + {8'd0, prod_reg[i][PROD_W-1:COLOUR_W]} + 16'd1;
        end
    end

    always_comb
    begin
        slot_valid_next = slot_valid_reg;
        slot_we         = 1'b0;
        if (cmd.exec_cmd)
        begin
            case (in_action_reg)
                ACT_SET:
                begin
                    if (level_ok)
                    begin
                        slot_we                    = 1'b1;
                        slot_valid_next[level_idx] = 1'b1;
                    end
                end
                ACT_RELEASE:
                begin
                    if (level_ok)
                    begin
                        slot_valid_next[level_idx] = 1'b0;
                    end
                end
                ACT_ALL_OFF:
                begin
                    slot_valid_next = '0;
                end
                default:
                begin
                    slot_valid_next = slot_valid_reg;
                end
            endcase
        end
    end

    // highest valid slot after this item's update
    always_comb
    begin
        top_found = 1'b0;
        top_idx   = '0;
        for (int i = 0; i < NUM_LEVELS; i++)
        begin
            if (slot_valid_next[i])
            begin
                top_found = 1'b1;
                top_idx   = LVL_W'(i);
            end
        end
    end

    always_comb
    begin
        act_entry_next = act_entry_reg;
        act_prio_next  = act_prio_reg;
        phase_next     = phase_reg;
        shown_next     = shown_reg;
        changed_next   = changed_reg;
        col_next       = col_reg;
        rem_next       = rem_reg;
        divr_next      = divr_reg;
        quot_next      = quot_reg;
        cnt_next       = cnt_reg;
        prod_next      = prod_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (cmd.exec_cmd)
        begin
            changed_next = 1'b0;
            if (in_action_reg == ACT_SET)
            begin
                if (level_ok && (in_level_reg >= act_prio_reg))
                begin
                    act_entry_next = in_req_reg;
                    act_prio_next  = in_level_reg;
                    phase_next     = '0;
                end
            end
            else if ((in_action_reg == ACT_ALL_OFF) ||
                     ((in_action_reg == ACT_RELEASE) && level_ok &&
                      (in_level_reg == act_prio_reg)))
            begin
                if (top_found)
                begin
                    act_entry_next = slot_entry_reg[top_idx];
                    act_prio_next  = LEVEL_W'(top_idx);
                    phase_next     = '0;
                end
                else
                begin
                    act_entry_next.effect = EFF_OFF;
                    act_prio_next         = '0;
                end
            end
        end

        if (cmd.tick_direct)
        begin
            case (act_entry_reg.effect)
                EFF_SOLID:
                begin
                    col_next = colour;
                end
                EFF_BLINK:
                begin
                    col_next = ((act_entry_reg.period == '0) || ph_lt_half) ? colour : '0;
                end
                EFF_PULSE:
                begin
                    col_next = colour;
                end
                default:
                begin
                    col_next = '0;
                end
            endcase
        end

        if (cmd.div_start)
        begin
            rem_next  = {bright_base, 8'd0} - {8'd0, bright_base};
            divr_next = {half, 8'd0};
            quot_next = '0;
            cnt_next  = '0;
        end

        if (cmd.div_step)
        begin
            if (rem_reg >= {1'b0, divr_reg})
            begin
                rem_next  = rem_reg - {1'b0, divr_reg};
                quot_next = {quot_reg[DIV_STEPS-2:0], 1'b1};
            end
            else
            begin
                quot_next = {quot_reg[DIV_STEPS-2:0], 1'b0};
            end
            divr_next = divr_reg >> 1;
            cnt_next  = cnt_reg + 4'd1;
        end

        if (cmd.mul)
        begin
            prod_next[0] = act_entry_reg.red * bright;
            prod_next[1] = act_entry_reg.green * bright;
            prod_next[2] = act_entry_reg.blue * bright;
        end

        if (cmd.scale)
        begin
            col_next = {scale_sum[0][PROD_W-1:COLOUR_W], scale_sum[1][PROD_W-1:COLOUR_W],
                        scale_sum[2][PROD_W-1:COLOUR_W]};
        end

        if (cmd.commit)
        begin
            changed_next = col_reg != shown_reg;
            shown_next   = col_reg;
            if (act_entry_reg.period == '0)
            begin
                phase_next = '0;
            end
            else if (phase_inc >= {1'b0, act_entry_reg.period})
            begin
                phase_next = '0;
            end
            else
            begin
                phase_next = phase_inc[PERIOD_W-1:0];
            end
        end

        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {3'd0, act_entry_reg.effect != EFF_OFF, act_prio_reg, changed_reg,
                              shown_reg[COLOUR_W-1:0] ^ {COLOUR_W{common_anode}},
                              shown_reg[2*COLOUR_W-1:COLOUR_W] ^ {COLOUR_W{common_anode}},
                              shown_reg[COL_W-1:2*COLOUR_W] ^ {COLOUR_W{common_anode}}};
        end
    end

    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_entry_reg[level_idx] <= in_req_reg;
        end
        if (cmd.load_in)
        begin
            in_action_reg <= action;
            in_level_reg  <= level;
            in_req_reg    <= req;
        end
        col_reg      <= col_next;
        rem_reg      <= rem_next;
        divr_reg     <= divr_next;
        quot_reg     <= quot_next;
        cnt_reg      <= cnt_next;
        prod_reg     <= prod_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= '0;
            act_entry_reg  <= '0;
            act_prio_reg   <= '0;
            phase_reg      <= '0;
            shown_reg      <= '0;
            changed_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            slot_valid_reg <= slot_valid_next;
            act_entry_reg  <= act_entry_next;
            act_prio_reg   <= act_prio_next;
            phase_reg      <= phase_next;
            shown_reg      <= shown_next;
            changed_reg    <= changed_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    assign status.is_tick  = in_action_reg == ACT_TICK;
    assign status.pulse    = (act_entry_reg.effect == EFF_PULSE) && (half != '0);
    assign status.div_last = cnt_reg == DIV_CNT_W'(DIV_STEPS - 1);
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

// ----- rtl/core/priority_rgb_led_effect_controller_core.sv -----
// ----------------------------------------------------------------------------
// priority_rgb_led_effect_controller_core
// prioritized rgb indicator driver with solid, blink and pulse effects
//
// channel   dir  handshake                 payload
// s_axis    in   s_tvalid / s_tready       s_tdata command fields, s_tuser action
// m_axis    out  m_tvalid / m_tready       m_tdata drive levels and status
// apb       in   psel / penable / pready   pwdata to common_anode, prdata back
//
// set, release and all-off items go straight to the result; solid, blink
// or off ticks go to commit; pulse ticks run the 9-step brightness divider
// one item is in work at a time; the output register lets the next item enter
// while a result waits for m_tready
// rst_n clears slot valid bits, active request, phase, shown colour, register
// ----------------------------------------------------------------------------
`default_nettype none

module priority_rgb_led_effect_controller_core #(
    parameter int NUM_LEVELS = prlec_pkg::NUM_LEVELS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // level, red_in, green_in, blue_in, effect, period
    input  wire logic [prlec_pkg::IN_DATA_W-1:0]     s_tdata,
    // action
    input  wire logic [1:0]                          s_tuser,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // pwm_red, pwm_green, pwm_blue, changed, active_level, lit
    output logic [prlec_pkg::OUT_DATA_W-1:0]         m_tdata,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [prlec_pkg::PADDR_W-1:0]       paddr,
    input  wire logic [prlec_pkg::PDATA_W-1:0]       pwdata,
    output logic [prlec_pkg::PDATA_W-1:0]            prdata,
    output logic                                     pready
);
    import prlec_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;
    led_entry_t req;
    logic       common_anode_reg;
    logic       common_anode_next;

    assign req.red    = s_tdata[10:3];
    assign req.green  = s_tdata[18:11];
    assign req.blue   = s_tdata[26:19];
    assign req.effect = s_tdata[28:27];
    assign req.period = s_tdata[44:29];

    assign pready = 1'b1;

    always_comb
    begin
        common_anode_next = common_anode_reg;
        if (psel && penable && pwrite && pready && (paddr == ADDR_COMMON_ANODE))
        begin
            common_anode_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            common_anode_reg <= 1'b0;
        end
        else
        begin
            common_anode_reg <= common_anode_next;
        end
    end

    assign prdata = (paddr == ADDR_COMMON_ANODE) ? {31'd0, common_anode_reg} : '0;

    prlec_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    prlec_datapath #(
        .NUM_LEVELS (NUM_LEVELS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .common_anode (common_anode_reg),
        .action       (s_tuser),
        .level        (s_tdata[2:0]),
        .req          (req),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_data     (m_tdata)
    );

endmodule

`default_nettype wire

// ----- rtl/core/prlec_chk.sv -----
// ----------------------------------------------------------------------------
// prlec_chk
// port-level checks of the led effect controller, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module prlec_chk #(
    parameter int NUM_LEVELS = prlec_pkg::NUM_LEVELS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    input  wire logic                               s_tready,
    input  wire logic                               m_tvalid,
    input  wire logic                               m_tready,
    input  wire logic [prlec_pkg::OUT_DATA_W-1:0]   m_tdata
);
    import prlec_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one item in work at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an item is in work");

    // dark output that reports a change is the same on all three colours
    a_dark_grey: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[28] && m_tdata[24] |->
            (m_tdata[7:0] == m_tdata[15:8]) && (m_tdata[15:8] == m_tdata[23:16]))
        else $error("changed to a non-dark colour while unlit");

    // active level stays inside the slot range
    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ({1'b0, m_tdata[27:25]} < 4'(NUM_LEVELS)))
        else $error("active level out of range");

endmodule

bind priority_rgb_led_effect_controller_core prlec_chk #(
    .NUM_LEVELS (NUM_LEVELS)
) u_prlec_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
